>>> hdl/ue2u_pkg.sv
package ue2u_pkg;

    // Characters that steer the escape parser
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

    // UTF-8 lead and continuation marks
    localparam logic [1:0] UTF8_CONT_MARK  = 2'b10;
    localparam logic [2:0] UTF8_LEAD2_MARK = 3'b110;
    localparam logic [3:0] UTF8_LEAD3_MARK = 4'b1110;

    // Most bytes one input item can cause: backslash, 'u' and four held bytes
    localparam int MAX_BURST  = 6;
    localparam int BURST_CW   = 3;
    localparam int HELD_DEPTH = 4;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        PH_PLAIN  = 2'd0,
        PH_SLASH  = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    // Bytes caused by one input item, oldest first
    typedef struct packed {
        logic [BURST_CW-1:0]           cnt;
        logic [0:MAX_BURST-1][7:0]     bytes;
    } t_burst;

    // Queue write side as seen from the front
    typedef struct packed {
        logic   valid;
        t_burst data;
    } t_push;

    // Queue read side as seen from the back
    typedef struct packed {
        logic   empty;
        t_burst head;
    } t_head;

    // Map a character to {not_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            res = {1'b0, c[3:0] + 4'd9};
        end
        return res;
    endfunction

endpackage

>>> hdl/ue2u_front.sv
module ue2u_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_stall,
    input  logic [7:0]     i_in_byte,
    input  logic           i_in_last,
    output ue2u_pkg::t_push o_push
);
    import ue2u_pkg::*;

    t_phase            r_phase, n_phase;
    logic [2:0]        r_count, n_count;
    logic [15:0]       r_code, n_code;
    logic              r_bad, n_bad;
    logic [7:0]        r_held [HELD_DEPTH];
    logic [7:0]        n_held [HELD_DEPTH];

    logic              w_accept;
    logic [4:0]        w_hex;
    logic              w_is_hex;
    logic [2:0]        w_cnt_inc;
    logic [15:0]       w_code_next;
    logic              w_bad_next;
    logic              w_finish;
    t_burst            w_burst;

    assign w_accept    = i_in_valid && !i_stall;
    assign w_hex       = hex_digit(i_in_byte);
    assign w_is_hex    = !w_hex[4];
    assign w_cnt_inc   = r_count + 3'd1;
    assign w_code_next = w_is_hex ? {r_code[11:0], w_hex[3:0]} : r_code;
    assign w_bad_next  = r_bad | !w_is_hex;
    assign w_finish    = (w_cnt_inc == 3'(HELD_DEPTH)) || i_in_last;

    // Held bytes with the current byte dropped into its slot
    always_comb begin
        for (int k = 0; k < HELD_DEPTH; k++) begin
            n_held[k] = (r_count[1:0] == 2'(k)) ? i_in_byte : r_held[k];
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            unique case (r_phase)
                PH_SLASH: begin
                    n_phase = (i_in_byte == CHAR_LOWER_U && !i_in_last) ? PH_DIGITS : PH_PLAIN;
                end
                PH_DIGITS: begin
                    n_phase = w_finish ? PH_PLAIN : PH_DIGITS;
                end
                default: begin
                    n_phase = (i_in_byte == CHAR_BACKSLASH && !i_in_last) ? PH_SLASH : PH_PLAIN;
                end
            endcase
        end
    end

    // Escape registers and the burst of bytes caused by this item
    always_comb begin
        n_count = r_count;
        n_code  = r_code;
        n_bad   = r_bad;
        w_burst = '0;
        if (w_accept) begin
            n_count = '0;
            n_code  = '0;
            n_bad   = 1'b0;
            unique case (r_phase)
                PH_SLASH: begin
                    w_burst.bytes[0] = CHAR_BACKSLASH;
                    if (i_in_byte == CHAR_LOWER_U) begin
                        // Lone backslash-u at the end of a message goes out raw
                        if (i_in_last) begin
                            w_burst.cnt      = 3'd2;
                            w_burst.bytes[1] = CHAR_LOWER_U;
                        end
                    end else begin
                        w_burst.cnt      = 3'd2;
                        w_burst.bytes[1] = i_in_byte;
                    end
                end
                PH_DIGITS: begin
                    if (!w_finish) begin
                        n_count = w_cnt_inc;
                        n_code  = w_code_next;
                        n_bad   = w_bad_next;
                    end else if (w_bad_next) begin
                        // Replay the whole escape raw
                        w_burst.cnt      = 3'd2 + w_cnt_inc;
                        w_burst.bytes[0] = CHAR_BACKSLASH;
                        w_burst.bytes[1] = CHAR_LOWER_U;
                        for (int k = 0; k < HELD_DEPTH; k++) begin
                            w_burst.bytes[2+k] = n_held[k];
                        end
                    end else if (w_code_next == 16'h0000) begin
                        w_burst.cnt = 3'd0;
                    end else if (w_code_next[15:7] == 9'd0) begin
                        w_burst.cnt      = 3'd1;
                        w_burst.bytes[0] = {1'b0, w_code_next[6:0]};
                    end else if (w_code_next[15:11] == 5'd0) begin
                        w_burst.cnt      = 3'd2;
                        w_burst.bytes[0] = {UTF8_LEAD2_MARK, w_code_next[10:6]};
                        w_burst.bytes[1] = {UTF8_CONT_MARK, w_code_next[5:0]};
                    end else begin
                        w_burst.cnt      = 3'd3;
                        w_burst.bytes[0] = {UTF8_LEAD3_MARK, w_code_next[15:12]};
                        w_burst.bytes[1] = {UTF8_CONT_MARK, w_code_next[11:6]};
                        w_burst.bytes[2] = {UTF8_CONT_MARK, w_code_next[5:0]};
                    end
                end
                default: begin
                    // Backslash at the end of a message goes out alone
                    if (i_in_byte != CHAR_BACKSLASH || i_in_last) begin
                        w_burst.cnt      = 3'd1;
                        w_burst.bytes[0] = i_in_byte;
                    end
                end
            endcase
        end
    end

    assign o_push.valid = w_accept && (w_burst.cnt != 3'd0);
    assign o_push.data  = w_burst;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_count <= '0;
            r_code  <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_code  <= n_code;
            r_bad   <= n_bad;
        end
    end

    // Held bytes of the open escape
    always_ff @(posedge i_clk) begin
        if (w_accept && r_phase == PH_DIGITS) begin
            r_held <= n_held;
        end
    end

endmodule

>>> hdl/ue2u_queue.sv
module ue2u_queue #(
    parameter int DEPTH = ue2u_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ue2u_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output ue2u_pkg::t_head o_head
);
    import ue2u_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_burst             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_wr, w_rd;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head.empty = (r_count == '0);
    assign o_head.head  = r_mem[r_rd_ptr];

    assign w_wr = i_push.valid && !o_full;
    assign w_rd = i_pop && !o_head.empty;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming burst
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

endmodule

>>> hdl/ue2u_back.sv
module ue2u_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ue2u_pkg::t_head i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);
    import ue2u_pkg::*;

    logic                 r_valid, n_valid;
    logic [7:0]           r_byte, n_byte;
    logic                 r_last, n_last;
    logic [BURST_CW-1:0]  r_idx, n_idx;
    logic                 w_load, w_take, w_end;

    assign w_load = !r_valid || !i_out_stall;
    assign w_take = w_load && !i_head.empty;
    assign w_end  = (r_idx == i_head.head.cnt - BURST_CW'(1));

    // Step through the head burst one byte at a time
    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_idx   = r_idx;
        if (w_load) begin
            n_valid = w_take;
        end
        if (w_take) begin
            n_byte = i_head.head.bytes[r_idx];
            n_last = w_end;
            n_idx  = w_end ? '0 : r_idx + BURST_CW'(1);
        end
    end

    assign o_pop = w_take && w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Output byte register
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_out_last  = r_last;

endmodule

>>> hdl/unicode_escape_to_utf8.sv
// Decodes backslash-u hex escapes in a byte stream into UTF-8. Each port
// moves one byte per cycle unless stalled; ordinary bytes go through the
// queue and the output register. An escape yields its one to three UTF-8
// bytes (none for code point zero), or goes out raw as up to six bytes if
// a collected byte is not hex, so a burst holds the input back only once
// the queue between parser and output stage (QUEUE_DEPTH bursts) has
// filled. o_out_last marks the final byte caused by an input byte; a
// partial escape is flushed when i_in_last is set.
module unicode_escape_to_utf8 #(
    parameter int QUEUE_DEPTH = ue2u_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    import ue2u_pkg::*;

    t_push w_push;
    t_head w_head;
    logic  w_full;
    logic  w_pop;

    assign o_in_stall = w_full;

    // Parse and classify input bytes
    ue2u_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stall    (w_full),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_push     (w_push)
    );

    // Hold bursts between parser and output stage
    ue2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    // Send bursts out a byte at a time
    ue2u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

>>> tb/testbench.sv
module testbench;
    import ue2u_pkg::*;

    // One text byte to offer, with the bytes it should cause where they are typed in
    typedef struct {
        logic [7:0]  b;
        logic        last;
        bit          typed;
        int          n;
        logic [31:0] e;
    } t_text_item;

    // One expected output byte
    typedef struct {
        logic [7:0] b;
        logic       last;
    } t_utf8_byte;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 240;
    localparam int RANDOM_ITEMS = 300;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_in_last   = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    // Decoder state as the predictor sees it
    t_phase      dec_phase;
    logic [2:0]  dec_count;
    logic [7:0]  dec_held [HELD_DEPTH];
    logic [15:0] dec_code;
    logic        dec_bad;

    logic [7:0]  emit_q [$];
    t_text_item  text_q [$];
    t_utf8_byte  utf8_q [$];

    int fail_count    = 0;
    int items_taken   = 0;
    int bytes_checked = 0;
    int idle_cycles   = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;

    unicode_escape_to_utf8 uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hex digit value, or -1 for any other byte
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    task automatic clear_escape();
        dec_phase = PH_PLAIN;
        dec_count = 3'd0;
        dec_code  = 16'h0000;
        dec_bad   = 1'b0;
    endtask

    // Emit the bytes of a completed escape: raw if any byte was not hex, else UTF-8
    task automatic close_escape();
        if (dec_bad) begin
            emit_q.push_back(CHAR_BACKSLASH);
            emit_q.push_back(CHAR_LOWER_U);
            for (int i = 0; i < int'(dec_count) && i < HELD_DEPTH; i++)
                emit_q.push_back(dec_held[i]);
        end else if (dec_code == 16'h0000) begin
            // code point zero: nothing goes out
        end else if (dec_code < 16'h0080) begin
            emit_q.push_back({1'b0, dec_code[6:0]});
        end else if (dec_code < 16'h0800) begin
            emit_q.push_back({UTF8_LEAD2_MARK, dec_code[10:6]});
            emit_q.push_back({UTF8_CONT_MARK, dec_code[5:0]});
        end else begin
            emit_q.push_back({UTF8_LEAD3_MARK, dec_code[15:12]});
            emit_q.push_back({UTF8_CONT_MARK, dec_code[11:6]});
            emit_q.push_back({UTF8_CONT_MARK, dec_code[5:0]});
        end
        clear_escape();
    endtask

    // Advance the decoder by one text byte; bytes it causes land in emit_q
    task automatic decode_item(input logic [7:0] b, input logic last);
        int h;
        emit_q.delete();
        case (dec_phase)
            PH_SLASH: begin
                if (b == CHAR_LOWER_U) begin
                    clear_escape();
                    dec_phase = PH_DIGITS;
                end else begin
                    emit_q.push_back(CHAR_BACKSLASH);
                    emit_q.push_back(b);
                    dec_phase = PH_PLAIN;
                end
            end
            PH_DIGITS: begin
                dec_held[dec_count[1:0]] = b;
                dec_count = dec_count + 3'd1;
                h = nibble_of(b);
                if (h < 0)
                    dec_bad = 1'b1;
                else
                    dec_code = {dec_code[11:0], h[3:0]};
                if (dec_count >= 3'd4)
                    close_escape();
            end
            default: begin
                if (b == CHAR_BACKSLASH) begin
                    dec_phase = PH_SLASH;
                end else begin
                    dec_phase = PH_PLAIN;
                    emit_q.push_back(b);
                end
            end
        endcase
        // Flush whatever is open at the end of a message
        if (last) begin
            if (dec_phase == PH_SLASH) begin
                emit_q.push_back(CHAR_BACKSLASH);
            end else if (dec_phase == PH_DIGITS) begin
                if (dec_count == 3'd0) begin
                    emit_q.push_back(CHAR_BACKSLASH);
                    emit_q.push_back(CHAR_LOWER_U);
                end else begin
                    close_escape();
                end
            end
            clear_escape();
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
                           input int n, input logic [31:0] e);
        t_text_item it;
        it.b = b;
        it.last = last;
        it.typed = typed;
        it.n = n;
        it.e = e;
        text_q.push_back(it);
    endtask

    task automatic add_text(input logic [7:0] b, input logic last);
        add_row(b, last, 1'b0, 0, 32'h0);
    endtask

    // Append one random stretch of text: plain bytes or one of several kinds of escape
    task automatic gen_fragment();
        int          kind;
        int          n;
        int          bad_pos;
        logic [15:0] cp;
        logic [7:0]  b;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_text(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
        end else if (kind < 65) begin
            case ($urandom_range(0, 19))
                0:             cp = 16'h0000;
                1, 2, 3, 4, 5: cp = 16'($urandom_range(16'h0001, 16'h007F));
                6, 7, 8, 9, 10: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                default:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            add_text(CHAR_BACKSLASH, 1'b0);
            add_text(CHAR_LOWER_U, 1'b0);
            for (int i = 3; i >= 0; i--)
                add_text(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))),
                         (i == 0) && ($urandom_range(0, 5) == 0));
        end else if (kind < 75) begin
            // short escape closed by the end of the message
            n = $urandom_range(1, 3);
            add_text(CHAR_BACKSLASH, 1'b0);
            add_text(CHAR_LOWER_U, 1'b0);
            for (int i = 0; i < n; i++)
                add_text(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                         i == n - 1);
        end else if (kind < 85) begin
            // escape with at least one non-hex byte, sometimes cut short
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 4;
            bad_pos = $urandom_range(0, n - 1);
            add_text(CHAR_BACKSLASH, 1'b0);
            add_text(CHAR_LOWER_U, 1'b0);
            for (int i = 0; i < n; i++) begin
                if (i == bad_pos || $urandom_range(0, 4) == 0) begin
                    do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
                end else begin
                    b = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                end
                add_text(b, (i == n - 1) && (n < 4 || $urandom_range(0, 5) == 0));
            end
        end else if (kind < 92) begin
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_LOWER_U);
            if ($urandom_range(0, 3) == 0) b = CHAR_BACKSLASH;
            add_text(CHAR_BACKSLASH, 1'b0);
            add_text(b, ($urandom_range(0, 4) == 0));
        end else if (kind < 96) begin
            add_text(CHAR_BACKSLASH, 1'b1);
        end else begin
            add_text(CHAR_BACKSLASH, 1'b0);
            add_text(CHAR_LOWER_U, 1'b1);
        end
    endtask

    // Receiver: shifting stall patterns, with one long hold-off on request
    initial begin
        t_stall_mode mode;
        int          mode_left;
        int          cyc;
        mode = STALL_NONE;
        mode_left = 0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:     i_out_stall <= 1'b0;
                    STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_PERIODIC: i_out_stall <= ((cyc % 5) >= 3);
                    default:        i_out_stall <= ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    // Check each output byte against the oldest expectation
    always @(posedge i_clk) begin
        t_utf8_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (utf8_q.size() == 0) begin
                $error("out_byte: no byte expected, got %02h (out_last %0b)",
                       o_out_byte, o_out_last);
                fail_count++;
            end else begin
                want = utf8_q.pop_front();
                bytes_checked++;
                if (o_out_byte !== want.b) begin
                    $error("out_byte: expected %02h, got %02h", want.b, o_out_byte);
                    fail_count++;
                end
                if (o_out_last !== want.last) begin
                    $error("out_last: expected %0b, got %0b", want.last, o_out_last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Sender: directed table, then random text in bursts
    initial begin
        t_text_item it;
        t_utf8_byte want;
        int         n_directed;
        int         hold_at;
        int         pause_at;
        int         burst_left;
        int         gap;

        clear_escape();
        foreach (dec_held[i]) dec_held[i] = 8'h00;

        // plain bytes at the extremes
        add_row(8'h41, 1'b0, 1'b1, 1, 32'h41000000);
        add_row(8'h00, 1'b0, 1'b1, 1, 32'h00000000);
        add_row(8'hFF, 1'b0, 1'b1, 1, 32'hFF000000);
        // largest code point, mixed-case digits
        add_row(CHAR_BACKSLASH, 1'b0, 1'b1, 0, 32'h0);
        add_row(CHAR_LOWER_U,   1'b0, 1'b1, 0, 32'h0);
        add_row(8'h46, 1'b0, 1'b1, 0, 32'h0);
        add_row(8'h66, 1'b0, 1'b1, 0, 32'h0);
        add_row(8'h46, 1'b0, 1'b1, 0, 32'h0);
        add_row(8'h66, 1'b0, 1'b1, 3, 32'hEFBFBF00);
        // non-hex byte, then the message ends mid-escape
        add_row(CHAR_BACKSLASH, 1'b0, 1'b1, 0, 32'h0);
        add_row(CHAR_LOWER_U,   1'b0, 1'b1, 0, 32'h0);
        add_row(8'h30, 1'b0, 1'b1, 0, 32'h0);
        add_row(8'h67, 1'b1, 1'b1, 4, 32'h5C753067);
        // backslash then backslash: the second does not open an escape
        add_row(CHAR_BACKSLASH, 1'b0, 1'b1, 0, 32'h0);
        add_row(CHAR_BACKSLASH, 1'b0, 1'b1, 2, 32'h5C5C0000);
        // message ends right after a backslash
        add_row(CHAR_BACKSLASH, 1'b1, 1'b1, 1, 32'h5C000000);
        // message ends right after backslash-u
        add_row(CHAR_BACKSLASH, 1'b0, 1'b1, 0, 32'h0);
        add_row(CHAR_LOWER_U,   1'b1, 1'b1, 2, 32'h5C750000);
        // code point zero from a one-digit escape
        add_row(CHAR_BACKSLASH, 1'b0, 1'b1, 0, 32'h0);
        add_row(CHAR_LOWER_U,   1'b0, 1'b1, 0, 32'h0);
        add_row(8'h30, 1'b1, 1'b1, 0, 32'h0);
        // surrogate code point
        add_text(CHAR_BACKSLASH, 1'b0);
        add_text(CHAR_LOWER_U, 1'b0);
        add_text(8'h64, 1'b0);
        add_text(8'h38, 1'b0);
        add_text(8'h30, 1'b0);
        add_text(8'h30, 1'b0);
        // short two-digit escape
        add_text(CHAR_BACKSLASH, 1'b0);
        add_text(CHAR_LOWER_U, 1'b0);
        add_text(8'h37, 1'b0);
        add_text(8'h46, 1'b1);

        n_directed = text_q.size();
        while (text_q.size() < n_directed + RANDOM_ITEMS)
            gen_fragment();
        hold_at = n_directed + 80;
        pause_at = n_directed + 200;
        burst_left = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (text_q[idx]) begin
            it = text_q[idx];
            if (idx == hold_at)
                hold_req = 1'b1;
            // drop valid and let every pending byte drain
            if (idx == pause_at) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (utf8_q.size() > 0) @(posedge i_clk);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            i_in_valid <= 1'b1;
            i_in_byte  <= it.b;
            i_in_last  <= it.last;
            do @(posedge i_clk); while (o_in_stall);
            items_taken++;
            decode_item(it.b, it.last);
            if (it.typed) begin
                for (int k = 0; k < it.n; k++) begin
                    want.b = it.e[31 - 8*k -: 8];
                    want.last = (k == it.n - 1);
                    utf8_q.push_back(want);
                end
            end else begin
                foreach (emit_q[k]) begin
                    want.b = emit_q[k];
                    want.last = (k == emit_q.size() - 1);
                    utf8_q.push_back(want);
                end
            end
        end
        i_in_valid <= 1'b0;

        // wait for the tail, then let the bench idle before the summary
        while (utf8_q.size() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d text bytes (%0d directed), checked %0d output bytes,",
                 items_taken, n_directed, bytes_checked);
        $display("with one long output hold-off and one full drain pause.");
        if (fail_count == 0 && utf8_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
